// ===== sv/fsgc_pkg.sv =====
`default_nettype none

package fsgc_pkg;

    // Header field widths
    localparam int THREAD_W = 10;
    localparam int DAY_W    = 17;
    localparam int SEC_W    = 17;
    localparam int FPS_W    = 24;
    localparam int LEN_W    = 27;
    localparam int GAP_W    = 32;

    // day*86400 + second fits 34 bits; times frames/s plus index fits 58
    localparam int SD_W  = 34;
    localparam int POS_W = SD_W + FPS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam int COUNT_BITS_DEF = 40;

    localparam logic [SEC_W-1:0]  SECONDS_PER_DAY   = 17'd86400;
    localparam logic [FPS_W-1:0]  FPS_RESET         = 24'd1;
    localparam logic [THREAD_W-1:0] THREAD_RESET    = 10'd0;
    localparam logic [LEN_W-1:0]  FRAME_BYTES_RESET = 27'd8032;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FPS         = 2'd0,
        CFG_THREAD      = 2'd1,
        CFG_FRAME_BYTES = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SD_RCV,
        ST_SD_EXP,
        ST_POS_RCV,
        ST_POS_EXP,
        ST_DIFF,
        ST_FIN
    } state_t;

    // Which product the shared multiply-add forms this cycle
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SD_RCV,
        MUL_SD_EXP,
        MUL_POS_RCV,
        MUL_POS_EXP
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     diff;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic need_pos;
        logic out_busy;
        logic halted;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/fsgc_in_if.sv =====
`default_nettype none

interface fsgc_in_if;
    logic                          valid;
    logic                          ready;
    logic [fsgc_pkg::THREAD_W-1:0] thread_id;
    logic [fsgc_pkg::DAY_W-1:0]    frame_day;
    logic [fsgc_pkg::SEC_W-1:0]    frame_second;
    logic [fsgc_pkg::FPS_W-1:0]    frame_index;
    logic [fsgc_pkg::LEN_W-1:0]    frame_length;

    modport source (
        output valid, thread_id, frame_day, frame_second, frame_index, frame_length,
        input  ready
    );

    modport sink (
        input  valid, thread_id, frame_day, frame_second, frame_index, frame_length,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/fsgc_out_if.sv =====
`default_nettype none

interface fsgc_out_if #(
    parameter int COUNT_BITS = fsgc_pkg::COUNT_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       matched;
    logic [fsgc_pkg::GAP_W-1:0] gap_frames;
    logic                       late_frame;
    logic [COUNT_BITS-1:0]      total_read;
    logic [COUNT_BITS-1:0]      total_missed;
    logic                       aborted;

    modport source (
        output valid, matched, gap_frames, late_frame, total_read, total_missed, aborted,
        input  ready
    );

    modport sink (
        input  valid, matched, gap_frames, late_frame, total_read, total_missed, aborted,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/frame_sequence_gap_counter.sv =====
// Sequence: a checked frame of a seeded stream, once accepted, makes four passes
//   through the shared 34x24 multiply-add, then one subtract and one commit;
//   every other frame goes from acceptance straight to the commit.
// Frames: a new frame is accepted only once the previous one has committed, and
//   the commit waits while the result register is held by the consumer.
// Reset: rst_n clears counts, expectation, seed and abort; registers take defaults.
`default_nettype none

module frame_sequence_gap_counter #(
    parameter int COUNT_BITS = fsgc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    fsgc_in_if.sink                              frame,
    fsgc_out_if.source                           result,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fsgc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    fsgc_pkg::cmd_t    cmd;
    fsgc_pkg::status_t status;

    // Sequencer
    fsgc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frame.valid),
        .in_ready (frame.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters, position arithmetic and result register
    fsgc_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .thread_id    (frame.thread_id),
        .frame_day    (frame.frame_day),
        .frame_second (frame.frame_second),
        .frame_index  (frame.frame_index),
        .frame_length (frame.frame_length),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .matched      (result.matched),
        .gap_frames   (result.gap_frames),
        .late_frame   (result.late_frame),
        .total_read   (result.total_read),
        .total_missed (result.total_missed),
        .aborted      (result.aborted),
        .cmd          (cmd),
        .status       (status)
    );

    // Abort is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(status.halted))
        else $error("abort flag cleared");

    // One request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready |=> !frame.ready)
        else $error("request accepted while busy");

    // Aborted results carry no match, gap or late mark
    a_abort_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.aborted |->
            !result.matched && result.gap_frames == '0 && !result.late_frame)
        else $error("aborted result reports activity");

    // A late frame is a matched one and adds no gap
    a_late_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.late_frame |-> result.matched && result.gap_frames == '0)
        else $error("late frame with gap");

endmodule

`default_nettype wire

// ===== sv/fsgc_ctrl.sv =====
`default_nettype none

module fsgc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fsgc_pkg::status_t status,
    output fsgc_pkg::cmd_t         cmd
);

    fsgc_pkg::state_t state_reg;
    fsgc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsgc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fsgc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // only a checked frame of a seeded stream needs positions
                    state_next = status.need_pos ? fsgc_pkg::ST_SD_RCV : fsgc_pkg::ST_FIN;
                end
            end
            fsgc_pkg::ST_SD_RCV:  state_next = fsgc_pkg::ST_SD_EXP;
            fsgc_pkg::ST_SD_EXP:  state_next = fsgc_pkg::ST_POS_RCV;
            fsgc_pkg::ST_POS_RCV: state_next = fsgc_pkg::ST_POS_EXP;
            fsgc_pkg::ST_POS_EXP: state_next = fsgc_pkg::ST_DIFF;
            fsgc_pkg::ST_DIFF:    state_next = fsgc_pkg::ST_FIN;
            fsgc_pkg::ST_FIN:
            begin
                // hold until the result register is free
                if (!status.out_busy)
                begin
                    state_next = fsgc_pkg::ST_IDLE;
                end
            end
            default:              state_next = fsgc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_sel = fsgc_pkg::MUL_NONE;
        cmd.diff    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            fsgc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            fsgc_pkg::ST_SD_RCV:  cmd.mul_sel = fsgc_pkg::MUL_SD_RCV;
            fsgc_pkg::ST_SD_EXP:  cmd.mul_sel = fsgc_pkg::MUL_SD_EXP;
            fsgc_pkg::ST_POS_RCV: cmd.mul_sel = fsgc_pkg::MUL_POS_RCV;
            fsgc_pkg::ST_POS_EXP: cmd.mul_sel = fsgc_pkg::MUL_POS_EXP;
            fsgc_pkg::ST_DIFF:    cmd.diff = 1'b1;
            fsgc_pkg::ST_FIN:     cmd.commit = !status.out_busy;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/fsgc_datapath.sv =====
`default_nettype none

module fsgc_datapath #(
    parameter int COUNT_BITS = fsgc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration writes
    input  wire logic                            cfg_wr_en,
    input  wire logic [fsgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fsgc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // request fields
    input  wire logic [fsgc_pkg::THREAD_W-1:0]   thread_id,
    input  wire logic [fsgc_pkg::DAY_W-1:0]      frame_day,
    input  wire logic [fsgc_pkg::SEC_W-1:0]      frame_second,
    input  wire logic [fsgc_pkg::FPS_W-1:0]      frame_index,
    input  wire logic [fsgc_pkg::LEN_W-1:0]      frame_length,
    // result register
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 matched,
    output logic [fsgc_pkg::GAP_W-1:0]           gap_frames,
    output logic                                 late_frame,
    output logic [COUNT_BITS-1:0]                total_read,
    output logic [COUNT_BITS-1:0]                total_missed,
    output logic                                 aborted,
    // control
    input  wire fsgc_pkg::cmd_t                  cmd,
    output fsgc_pkg::status_t                    status
);

    localparam int SD_W  = fsgc_pkg::SD_W;
    localparam int POS_W = fsgc_pkg::POS_W;
    localparam int FPS_W = fsgc_pkg::FPS_W;
    localparam int DAY_W = fsgc_pkg::DAY_W;
    localparam int SEC_W = fsgc_pkg::SEC_W;
    localparam int GAP_W = fsgc_pkg::GAP_W;
    localparam int SUM_W = ((COUNT_BITS > POS_W) ? COUNT_BITS : POS_W) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [GAP_W-1:0]      GAP_MAX   = {GAP_W{1'b1}};

    // Configuration registers
    logic [FPS_W-1:0]              fps_reg;
    logic [fsgc_pkg::THREAD_W-1:0] target_reg;
    logic [fsgc_pkg::LEN_W-1:0]    frame_bytes_reg;

    // Stream state
    logic                  seeded_reg,  seeded_next;
    logic                  halted_reg,  halted_next;
    logic [DAY_W-1:0]      nday_reg,    nday_next;
    logic [SEC_W-1:0]      nsec_reg,    nsec_next;
    logic [FPS_W-1:0]      nidx_reg,    nidx_next;
    logic [COUNT_BITS-1:0] read_reg,    read_next;
    logic [COUNT_BITS-1:0] missed_reg,  missed_next;

    // Latched request
    logic [DAY_W-1:0] day_reg;
    logic [SEC_W-1:0] sec_reg;
    logic [FPS_W-1:0] idx_reg;
    logic             halt_hit_reg;
    logic             match_reg;
    logic             pos_chk_reg;

    // Position work registers
    logic [SD_W-1:0]  sd_rcv_reg;
    logic [SD_W-1:0]  sd_exp_reg;
    logic [POS_W-1:0] pos_rcv_reg;
    logic [POS_W-1:0] pos_exp_reg;
    logic [POS_W-1:0] diff_reg;
    logic             late_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  matched_reg;
    logic [GAP_W-1:0]      gap_reg,  gap_next;
    logic                  late_out_reg;
    logic [COUNT_BITS-1:0] total_read_reg;
    logic [COUNT_BITS-1:0] total_missed_reg;
    logic                  aborted_reg;

    logic [FPS_W-1:0] fps_eff;
    logic             len_ok;
    logic             thread_hit;
    logic [SD_W-1:0]  mul_a;
    logic [FPS_W-1:0] mul_b;
    logic [FPS_W-1:0] mul_c;
    logic [POS_W-1:0] mul_res;
    logic [POS_W:0]   sub_res;
    logic [SUM_W-1:0] miss_sum;
    logic             gap_on;

    // A zero rate counts as one frame per second
    assign fps_eff    = (fps_reg == '0) ? FPS_W'(1) : fps_reg;
    assign len_ok     = (frame_length == frame_bytes_reg);
    assign thread_hit = (thread_id == target_reg);

    assign status.need_pos = !halted_reg && len_ok && thread_hit && seeded_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign status.halted   = halted_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg         <= fsgc_pkg::FPS_RESET;
            target_reg      <= fsgc_pkg::THREAD_RESET;
            frame_bytes_reg <= fsgc_pkg::FRAME_BYTES_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (fsgc_pkg::cfg_idx_t'(cfg_index))
                fsgc_pkg::CFG_FPS:
                    fps_reg <= cfg_wr_data[FPS_W-1:0];
                fsgc_pkg::CFG_THREAD:
                    target_reg <= cfg_wr_data[fsgc_pkg::THREAD_W-1:0];
                fsgc_pkg::CFG_FRAME_BYTES:
                    frame_bytes_reg <= cfg_wr_data[fsgc_pkg::LEN_W-1:0];
                default:
                begin
                    fps_reg <= fps_reg;
                end
            endcase
        end
    end

    // Capture the request and classify it against the current state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg      <= frame_day;
            sec_reg      <= frame_second;
            idx_reg      <= frame_index;
            halt_hit_reg <= !halted_reg && !len_ok;
            match_reg    <= !halted_reg && len_ok && thread_hit;
            pos_chk_reg  <= status.need_pos;
        end
    end

    // Shared multiply-add: a * b + c
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        case (cmd.mul_sel)
            fsgc_pkg::MUL_SD_RCV:
            begin
                mul_a = SD_W'(day_reg);
                mul_b = FPS_W'(fsgc_pkg::SECONDS_PER_DAY);
                mul_c = FPS_W'(sec_reg);
            end
            fsgc_pkg::MUL_SD_EXP:
            begin
                mul_a = SD_W'(nday_reg);
                mul_b = FPS_W'(fsgc_pkg::SECONDS_PER_DAY);
                mul_c = FPS_W'(nsec_reg);
            end
            fsgc_pkg::MUL_POS_RCV:
            begin
                mul_a = sd_rcv_reg;
                mul_b = fps_eff;
                mul_c = idx_reg;
            end
            fsgc_pkg::MUL_POS_EXP:
            begin
                mul_a = sd_exp_reg;
                mul_b = fps_eff;
                mul_c = nidx_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
        mul_res = POS_W'(mul_a) * POS_W'(mul_b) + POS_W'(mul_c);
    end

    assign sub_res = {1'b0, pos_rcv_reg} - {1'b0, pos_exp_reg};

    // Position registers
    always_ff @(posedge clk)
    begin
        case (cmd.mul_sel)
            fsgc_pkg::MUL_SD_RCV:  sd_rcv_reg  <= mul_res[SD_W-1:0];
            fsgc_pkg::MUL_SD_EXP:  sd_exp_reg  <= mul_res[SD_W-1:0];
            fsgc_pkg::MUL_POS_RCV: pos_rcv_reg <= mul_res;
            fsgc_pkg::MUL_POS_EXP: pos_exp_reg <= mul_res;
            default:
            begin
                sd_rcv_reg <= sd_rcv_reg;
            end
        endcase
        if (cmd.diff)
        begin
            diff_reg <= sub_res[POS_W-1:0];
            late_reg <= sub_res[POS_W];
        end
    end

    // Commit values
    always_comb
    begin
        gap_on      = pos_chk_reg && !late_reg;
        miss_sum    = SUM_W'(missed_reg) + SUM_W'(diff_reg);
        halted_next = halted_reg || halt_hit_reg;
        seeded_next = seeded_reg;
        nday_next   = nday_reg;
        nsec_next   = nsec_reg;
        nidx_next   = nidx_reg;
        read_next   = read_reg;
        missed_next = missed_reg;
        gap_next    = '0;
        if (match_reg)
        begin
            seeded_next = 1'b1;
            if (read_reg != COUNT_MAX)
            begin
                read_next = read_reg + COUNT_BITS'(1);
            end
            if (gap_on)
            begin
                missed_next = (miss_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                             : miss_sum[COUNT_BITS-1:0];
                gap_next    = (diff_reg > POS_W'(GAP_MAX)) ? GAP_MAX : diff_reg[GAP_W-1:0];
            end
            // expectation moves to the frame after this one
            if (idx_reg >= fps_eff - FPS_W'(1))
            begin
                nidx_next = '0;
                if (sec_reg >= fsgc_pkg::SECONDS_PER_DAY - SEC_W'(1))
                begin
                    nsec_next = '0;
                    nday_next = day_reg + DAY_W'(1);
                end
                else
                begin
                    nsec_next = sec_reg + SEC_W'(1);
                    nday_next = day_reg;
                end
            end
            else
            begin
                nidx_next = idx_reg + FPS_W'(1);
                nsec_next = sec_reg;
                nday_next = day_reg;
            end
        end
    end

    // Stream state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            halted_reg <= 1'b0;
            nday_reg   <= '0;
            nsec_reg   <= '0;
            nidx_reg   <= '0;
            read_reg   <= '0;
            missed_reg <= '0;
        end
        else if (cmd.commit)
        begin
            seeded_reg <= seeded_next;
            halted_reg <= halted_next;
            nday_reg   <= nday_next;
            nsec_reg   <= nsec_next;
            nidx_reg   <= nidx_next;
            read_reg   <= read_next;
            missed_reg <= missed_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            matched_reg      <= match_reg;
            gap_reg          <= gap_next;
            late_out_reg     <= match_reg && pos_chk_reg && late_reg;
            total_read_reg   <= read_next;
            total_missed_reg <= missed_next;
            aborted_reg      <= halted_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign gap_frames   = gap_reg;
    assign late_frame   = late_out_reg;
    assign total_read   = total_read_reg;
    assign total_missed = total_missed_reg;
    assign aborted      = aborted_reg;

endmodule

`default_nettype wire
